### hdl/vdb_pkg.sv
package vdb_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int ANGLE_BITS_DEF = 16;
	localparam int ITERATIONS_DEF = 16;

	// Fractional guard bits kept below the coordinate LSB inside the rotator.
	localparam int GUARD = 24;

	localparam int DIST_W = 17;
	localparam int BEAR_W = 16;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_REF_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REF_Y = 2'd1;

	// atan(2^-i) as a fraction of a turn, scaled by 2^32.
	function automatic logic [31:0] atan_turns(input int i);
		logic [31:0] a;
		case (i)
			0:       a = 32'd536870912;
			1:       a = 32'd316933406;
			2:       a = 32'd167458907;
			3:       a = 32'd85004756;
			4:       a = 32'd42667331;
			5:       a = 32'd21354465;
			6:       a = 32'd10679838;
			7:       a = 32'd5340245;
			8:       a = 32'd2670163;
			9:       a = 32'd1335087;
			10:      a = 32'd667544;
			11:      a = 32'd333772;
			12:      a = 32'd166886;
			13:      a = 32'd83443;
			14:      a = 32'd41722;
			15:      a = 32'd20861;
			16:      a = 32'd10430;
			17:      a = 32'd5215;
			18:      a = 32'd2608;
			19:      a = 32'd1304;
			20:      a = 32'd652;
			21:      a = 32'd326;
			22:      a = 32'd163;
			23:      a = 32'd81;
			default: a = 32'd0;
		endcase
		return a;
	endfunction

endpackage

### hdl/vector_distance_and_bearing.sv
// Distance and bearing from a configured reference point to each target point.
// One transaction is taken per clock while in_ready is high. After a subtract stage,
// a squaring stage and a sum stage, each further pipeline stage runs at most one
// CORDIC vectoring micro-rotation and one restoring square-root digit. A two-entry
// output buffer decouples the sides: in_ready drops only while two results wait to
// be taken. The reference point is written through the cfg channel (index 0 for x,
// index 1 for y); the user must do so only while no transaction is in flight, which
// the block does not enforce.
module vector_distance_and_bearing #(
	parameter int COORD_BITS = vdb_pkg::COORD_BITS_DEF,
	parameter int ANGLE_BITS = vdb_pkg::ANGLE_BITS_DEF,
	parameter int ITERATIONS = vdb_pkg::ITERATIONS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [vdb_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [COORD_BITS-1:0]                cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [COORD_BITS-1:0]         target_x,
	input  logic signed [COORD_BITS-1:0]         target_y,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [vdb_pkg::DIST_W-1:0]           distance,
	output logic [vdb_pkg::BEAR_W-1:0]           bearing
);

	localparam int C   = COORD_BITS;
	localparam int DW  = C + 1;
	localparam int RW  = C + 1;
	localparam int RMW = RW + 3;
	localparam int XW  = C + vdb_pkg::GUARD + 3;
	localparam int NST = (ITERATIONS > RW) ? ITERATIONS : RW;
	localparam logic [31:0] ROUND_K = 32'd1 << (31 - ANGLE_BITS);
	localparam logic [31:0] HALF_TURN = 32'h8000_0000;

	logic signed [C-1:0] ref_x_q, ref_y_q;

	logic adv;

	logic                 v_s1, v_s2;
	logic signed [DW-1:0] dx_s1, dy_s1;
	logic [2*C-1:0]       sq_x_s2, sq_y_s2;
	logic signed [XW-1:0] cx_s2, cy_s2;
	logic [31:0]          ang_s2;
	logic                 zero_s2;

	// Element 0 is the third stage (sum); element j+1 is written by stage j.
	logic                 v_s    [NST+1];
	logic signed [XW-1:0] cx_s   [NST+1];
	logic signed [XW-1:0] cy_s   [NST+1];
	logic [31:0]          ang_s  [NST+1];
	logic                 zero_s [NST+1];
	logic [2*RW-1:0]      rad_s  [NST+1];
	logic [RMW-1:0]       rem_s  [NST+1];
	logic [RW-1:0]        root_s [NST+1];

	logic [RW-1:0]              root_rnd;
	logic [31:0]                ang_rnd;
	logic [ANGLE_BITS-1:0]      bear_full;
	logic [vdb_pkg::DIST_W-1:0] push_dist;
	logic [vdb_pkg::BEAR_W-1:0] push_bear;
	logic                       push, pop;

	logic                       out_valid_q, skid_valid_q;
	logic [vdb_pkg::DIST_W-1:0] out_dist_q, skid_dist_q;
	logic [vdb_pkg::BEAR_W-1:0] out_bear_q, skid_bear_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_x_q <= '0;
			ref_y_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				vdb_pkg::REG_REF_X: ref_x_q <= cfg_data;
				vdb_pkg::REG_REF_Y: ref_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The whole pipeline moves together; it halts only when both output slots are full.
	assign adv      = !(out_valid_q && skid_valid_q);
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s[0] <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s[0] <= v_s2;
		end
	end

	// Stage 1: exact differences.
	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1 <= DW'(target_x) - DW'(ref_x_q);
			dy_s1 <= DW'(target_y) - DW'(ref_y_q);
		end
	end

	// Stage 2: squares of the magnitudes, and the rotator start point. A vector in the
	// left half-plane is turned by a half turn so the rotations start with x >= 0.
	logic [C-1:0]         ax, ay;
	logic signed [XW-1:0] x_ext, y_ext;

	always_comb begin
		ax    = dx_s1[DW-1] ? C'(-dx_s1) : C'(dx_s1);
		ay    = dy_s1[DW-1] ? C'(-dy_s1) : C'(dy_s1);
		x_ext = XW'(dx_s1) <<< vdb_pkg::GUARD;
		y_ext = XW'(dy_s1) <<< vdb_pkg::GUARD;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_x_s2 <= ax * ax;
			sq_y_s2 <= ay * ay;
			zero_s2 <= (dx_s1 == '0) && (dy_s1 == '0);
			if (dx_s1[DW-1]) begin
				cx_s2  <= -x_ext;
				cy_s2  <= -y_ext;
				ang_s2 <= HALF_TURN;
			end else begin
				cx_s2  <= x_ext;
				cy_s2  <= y_ext;
				ang_s2 <= '0;
			end
		end
	end

	// Stage 3: sum of squares becomes the square-root radicand.
	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s[0]  <= (2*RW)'(sq_x_s2) + (2*RW)'(sq_y_s2);
			rem_s[0]  <= '0;
			root_s[0] <= '0;
			cx_s[0]   <= cx_s2;
			cy_s[0]   <= cy_s2;
			ang_s[0]  <= ang_s2;
			zero_s[0] <= zero_s2;
		end
	end

	for (genvar j = 0; j < NST; j++) begin : g_stage
		logic signed [XW-1:0] x_nxt, y_nxt;
		logic [31:0]          a_nxt;
		logic [2*RW-1:0]      rad_nxt;
		logic [RMW-1:0]       rem_nxt;
		logic [RW-1:0]        root_nxt;

		if (j < ITERATIONS) begin : g_rot
			logic signed [XW-1:0] xs, ys;
			always_comb begin
				xs = cx_s[j] >>> j;
				ys = cy_s[j] >>> j;
				if (!cy_s[j][XW-1]) begin
					x_nxt = cx_s[j] + ys;
					y_nxt = cy_s[j] - xs;
					a_nxt = ang_s[j] + vdb_pkg::atan_turns(j);
				end else begin
					x_nxt = cx_s[j] - ys;
					y_nxt = cy_s[j] + xs;
					a_nxt = ang_s[j] - vdb_pkg::atan_turns(j);
				end
			end
		end else begin : g_rot_idle
			assign x_nxt = cx_s[j];
			assign y_nxt = cy_s[j];
			assign a_nxt = ang_s[j];
		end

		if (j < RW) begin : g_root
			logic [RMW-1:0] rem_sh, trial;
			always_comb begin
				rem_sh  = {rem_s[j][RMW-3:0], rad_s[j][2*RW-1 -: 2]};
				trial   = {1'b0, root_s[j], 2'b01};
				rad_nxt = rad_s[j] << 2;
				if (rem_sh >= trial) begin
					rem_nxt  = rem_sh - trial;
					root_nxt = {root_s[j][RW-2:0], 1'b1};
				end else begin
					rem_nxt  = rem_sh;
					root_nxt = {root_s[j][RW-2:0], 1'b0};
				end
			end
		end else begin : g_root_idle
			assign rad_nxt  = rad_s[j];
			assign rem_nxt  = rem_s[j];
			assign root_nxt = root_s[j];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (adv) begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				cx_s[j+1]   <= x_nxt;
				cy_s[j+1]   <= y_nxt;
				ang_s[j+1]  <= a_nxt;
				zero_s[j+1] <= zero_s[j];
				rad_s[j+1]  <= rad_nxt;
				rem_s[j+1]  <= rem_nxt;
				root_s[j+1] <= root_nxt;
			end
		end
	end

	// Round both results on the way into the output buffer.
	always_comb begin
		root_rnd  = root_s[NST] + RW'(rem_s[NST] > RMW'(root_s[NST]));
		ang_rnd   = ang_s[NST] + ROUND_K;
		bear_full = ang_rnd[31 -: ANGLE_BITS];
		push_dist = vdb_pkg::DIST_W'(root_rnd);
		push_bear = zero_s[NST] ? '0 : vdb_pkg::BEAR_W'(bear_full);
	end

	assign push = adv && v_s[NST];
	assign pop  = out_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= skid_valid_q && push;
		end else if (out_valid_q) begin
			skid_valid_q <= skid_valid_q || push;
		end else begin
			out_valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				out_dist_q  <= skid_dist_q;
				out_bear_q  <= skid_bear_q;
				skid_dist_q <= push_dist;
				skid_bear_q <= push_bear;
			end else begin
				out_dist_q <= push_dist;
				out_bear_q <= push_bear;
			end
		end else if (out_valid_q) begin
			if (!skid_valid_q) begin
				skid_dist_q <= push_dist;
				skid_bear_q <= push_bear;
			end
		end else begin
			out_dist_q <= push_dist;
			out_bear_q <= push_bear;
		end
	end

	assign out_valid = out_valid_q;
	assign distance  = out_dist_q;
	assign bearing   = out_bear_q;

	// The spare output slot is only ever filled behind an occupied head slot.
	assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("output spare slot holds a result while the head slot is empty");

	// Only the same point gives a zero distance, and then the bearing is zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && distance == '0) |-> (bearing == '0))
		else $error("zero distance with nonzero bearing");

	// A finished result at the pipeline end is kept while the buffer is full.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!in_ready && v_s[NST]) |=> v_s[NST])
		else $error("result at pipeline end lost during a stall");

	// A stall holds the payload at the end of the pipeline.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!in_ready && v_s[NST]) |=> $stable(root_s[NST]) && $stable(ang_s[NST]))
		else $error("pipeline end payload changed during a stall");

endmodule

### tb/sv/vdb_checker.sv
module vdb_checker (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_valid,
	input  logic                                    cfg_ready,
	input  logic [vdb_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [vdb_pkg::COORD_BITS_DEF-1:0]      cfg_data,
	input  logic                                    in_valid,
	input  logic                                    in_ready,
	input  logic signed [vdb_pkg::COORD_BITS_DEF-1:0] target_x,
	input  logic signed [vdb_pkg::COORD_BITS_DEF-1:0] target_y,
	input  logic                                    out_valid,
	input  logic                                    out_ready,
	input  logic [vdb_pkg::DIST_W-1:0]              distance,
	input  logic [vdb_pkg::BEAR_W-1:0]              bearing,
	output int                                      fail_count,
	output int                                      pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB = vdb_pkg::COORD_BITS_DEF;
	localparam int AB = vdb_pkg::ANGLE_BITS_DEF;
	localparam int NIT = vdb_pkg::ITERATIONS_DEF;

	typedef struct packed {
		logic [vdb_pkg::DIST_W-1:0] distance;
		logic [vdb_pkg::BEAR_W-1:0] bearing;
	} fix_t;

	// Micro-rotation angles, atan(2^-k) in turns scaled by 2^32.
	logic [31:0] rot_angle [0:15] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
		32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
		32'd166886, 32'd83443, 32'd41722, 32'd20861
	};

	logic signed [CB-1:0] ref_x_q;
	logic signed [CB-1:0] ref_y_q;
	fix_t fixes_due [$];

	function automatic fix_t locate_target(logic signed [CB-1:0] tx, logic signed [CB-1:0] ty);
		fix_t r;
		longint dx, dy, cx, cy, cxs, cys;
		longint unsigned sq, rem, root, trial;
		logic [31:0] ang;
		dx = longint'(tx) - longint'(ref_x_q);
		dy = longint'(ty) - longint'(ref_y_q);
		sq = longint'(dx * dx + dy * dy);

		// Restoring square root, two bits per digit; the sum is below 2^34.
		rem = 0;
		root = 0;
		for (int k = 16; k >= 0; k--) begin
			rem = (rem << 2) | ((sq >> (2 * k)) & 64'd3);
			trial = (root << 2) | 64'd1;
			if (rem >= trial) begin
				rem = rem - trial;
				root = (root << 1) | 64'd1;
			end else begin
				root = root << 1;
			end
		end
		if (rem > root)
			root = root + 1;
		r.distance = root[vdb_pkg::DIST_W-1:0];

		r.bearing = '0;
		if (dx != 0 || dy != 0) begin
			cx = dx <<< vdb_pkg::GUARD;
			cy = dy <<< vdb_pkg::GUARD;
			ang = 32'h0;
			// Left half plane: rotate by a half turn first.
			if (cx < 0) begin
				cx = -cx;
				cy = -cy;
				ang = 32'h8000_0000;
			end
			for (int k = 0; k < NIT; k++) begin
				cxs = cx >>> k;
				cys = cy >>> k;
				if (cy >= 0) begin
					cx = cx + cys;
					cy = cy - cxs;
					ang = ang + rot_angle[k];
				end else begin
					cx = cx - cys;
					cy = cy + cxs;
					ang = ang - rot_angle[k];
				end
			end
			ang = ang + (32'd1 << (31 - AB));
			r.bearing = ang[31 -: AB];
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		fix_t want;
		if (!arst_n) begin
			ref_x_q = '0;
			ref_y_q = '0;
			fixes_due.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == vdb_pkg::REG_REF_X)
					ref_x_q = cfg_data;
				else if (cfg_index == vdb_pkg::REG_REF_Y)
					ref_y_q = cfg_data;
			end
			if (out_valid && out_ready) begin
				if (fixes_due.size() == 0) begin
					$error("unexpected result transaction: distance %0d, bearing %0d",
						distance, bearing);
					fail_count++;
				end else begin
					want = fixes_due.pop_front();
					if (distance !== want.distance) begin
						$error("distance: expected %0d, actual %0d", want.distance, distance);
						fail_count++;
					end
					if (bearing !== want.bearing) begin
						$error("bearing: expected %0d, actual %0d", want.bearing, bearing);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready)
				fixes_due.push_back(locate_target(target_x, target_y));
			pending = fixes_due.size();
		end
	end

endmodule

### tb/sv/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB = vdb_pkg::COORD_BITS_DEF;
	// Indexes that decode to no register.
	localparam logic [vdb_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [vdb_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
	localparam logic signed [CB-1:0] C_MAX = 16'sh7FFF;
	localparam logic signed [CB-1:0] C_MIN = -16'sh8000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [vdb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [CB-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [CB-1:0] target_x = '0;
	logic signed [CB-1:0] target_y = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [vdb_pkg::DIST_W-1:0] distance;
	logic [vdb_pkg::BEAR_W-1:0] bearing;

	int fail_count;
	int pending;
	int n_sent = 0;
	int n_recv = 0;
	bit quiet = 1'b0;
	int hold_asks = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int rx_idle_left = 0;
	logic signed [CB-1:0] ref_x_now = '0;
	logic signed [CB-1:0] ref_y_now = '0;

	always #5 clk = ~clk;

	vector_distance_and_bearing i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.target_x  (target_x),
		.target_y  (target_y),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.distance  (distance),
		.bearing   (bearing)
	);

	vdb_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.target_x   (target_x),
		.target_y   (target_y),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.distance   (distance),
		.bearing    (bearing),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Result side: random stalls, plus a long hold-off whenever one is asked for.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				n_recv <= n_recv + 1;
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (hold_seen != hold_asks) begin
				hold_seen <= hold_asks;
				out_ready <= 1'b0;
				hold_left <= 300;
			end else if (rx_idle_left > 0) begin
				out_ready <= 1'b0;
				rx_idle_left <= rx_idle_left - 1;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				out_ready <= 1'b0;
				rx_idle_left <= $urandom_range(1, 14) - 1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic write_reg(logic [vdb_pkg::CFG_IDX_W-1:0] idx, logic [CB-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Lets every transaction in flight drain out before the reference moves.
	task automatic settle();
		in_valid <= 1'b0;
		while (n_recv < n_sent)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic set_ref(logic signed [CB-1:0] rx, logic signed [CB-1:0] ry, bit junk);
		settle();
		if (junk)
			write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, CB'($urandom));
		write_reg(vdb_pkg::REG_REF_X, rx);
		write_reg(vdb_pkg::REG_REF_Y, ry);
		if (junk)
			write_reg(REG_SPARE_3, ~rx);
		cfg_valid <= 1'b0;
		ref_x_now = rx;
		ref_y_now = ry;
	endtask

	task automatic send_point(logic signed [CB-1:0] tx, logic signed [CB-1:0] ty);
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 14);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		target_x <= tx;
		target_y <= ty;
		do @(posedge clk); while (!in_ready);
		n_sent++;
	endtask

	// Mostly random targets, with a share near the reference, on its axes and
	// diagonals, and on top of it.
	task automatic send_random_point();
		logic signed [CB-1:0] tx, ty, d;
		int pick;
		pick = $urandom_range(0, 19);
		d = CB'($urandom_range(0, 128)) - 16'sd64;
		if (pick < 11) begin
			tx = CB'($urandom);
			ty = CB'($urandom);
		end else if (pick < 16) begin
			tx = ref_x_now + d;
			ty = ref_y_now + (CB'($urandom_range(0, 128)) - 16'sd64);
		end else if (pick == 16) begin
			tx = ref_x_now;
			ty = CB'($urandom);
		end else if (pick == 17) begin
			tx = CB'($urandom);
			ty = ref_y_now;
		end else if (pick == 18) begin
			d = CB'($urandom) >>> $urandom_range(0, 15);
			tx = ref_x_now + d;
			ty = $urandom_range(0, 1) ? ref_y_now + d : ref_y_now - d;
		end else begin
			tx = ref_x_now;
			ty = ref_y_now;
		end
		send_point(tx, ty);
	endtask

	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		logic signed [CB-1:0] rx, ry;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reference at the origin; writes to spare indexes must not move it.
		set_ref('0, '0, 1'b0);
		@(posedge clk);
		write_reg(REG_SPARE_2, 16'h7FFF);
		write_reg(REG_SPARE_3, 16'h8000);
		cfg_valid <= 1'b0;
		send_point(0, 0);
		send_point(1, 0);
		send_point(-1, 0);
		send_point(0, 1);
		send_point(0, -1);
		send_point(1, 1);
		send_point(-1, -1);
		send_point(1, -1);
		send_point(C_MAX, 0);
		send_point(C_MIN, 0);
		send_point(0, C_MAX);
		send_point(0, C_MIN);
		send_point(C_MAX, C_MAX);
		send_point(C_MIN, C_MIN);
		send_point(C_MAX, C_MIN);
		send_point(C_MIN, C_MAX);

		// Opposite corners give the largest offsets in each direction.
		set_ref(C_MIN, C_MIN, 1'b1);
		send_point(C_MAX, C_MAX);
		send_point(C_MIN, C_MIN);
		send_point(C_MAX, C_MIN);
		set_ref(C_MAX, C_MAX, 1'b1);
		send_point(C_MIN, C_MIN);
		send_point(C_MAX, C_MAX);
		send_point(C_MIN, C_MAX);

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				1: begin rx = C_MIN; ry = C_MAX; end
				3: begin rx = C_MAX; ry = C_MIN; end
				5: begin rx = '0; ry = '0; end
				6: begin rx = C_MAX; ry = C_MAX; end
				default: begin rx = CB'($urandom); ry = CB'($urandom); end
			endcase
			set_ref(rx, ry, $urandom_range(0, 1));
			// The final phase runs with both sides always ready.
			if (ph == 7)
				quiet = 1'b1;
			for (int n = 0; n < 160; n++) begin
				if (ph == 1 && n == 40)
					hold_asks++;
				send_random_point();
			end
		end

		in_valid <= 1'b0;
		while (n_recv < n_sent)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

### filelist.f
hdl/vdb_pkg.sv
hdl/vector_distance_and_bearing.sv
tb/sv/vdb_checker.sv
tb/sv/tb_top.sv
